FILE: rtl/assert_macros.svh
// assertion macros used by the session table rtl
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/stc_pkg.sv
// types, sizes and codes of the session table
// no dependencies
package stc_pkg;

    localparam int SESSIONS            = 16;
    localparam int COOKIES_PER_SESSION = 4;
    localparam int IDX_W = $clog2(SESSIONS);
    localparam int N_W   = $clog2(SESSIONS + 1);
    localparam int CNT_W = $clog2(COOKIES_PER_SESSION + 1);
    localparam int SLOT_W = (COOKIES_PER_SESSION > 1) ? $clog2(COOKIES_PER_SESSION) : 1;

    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [8:0]  PROTO_ABSENT = 9'h100;
    localparam logic [31:0] IP_ABSENT    = 32'hFFFF_FFFF;
    localparam logic [16:0] PORT_ABSENT  = 17'h1_0000;

    localparam logic       OP_PACKET = 1'b0;
    localparam logic       OP_REMOVE = 1'b1;
    localparam logic [1:0] REASON_IDLE   = 2'd0;
    localparam logic [1:0] REASON_HARD   = 2'd1;
    localparam logic [1:0] REASON_DELETE = 2'd2;
    localparam logic [1:0] REASON_GROUP  = 2'd3;

    localparam logic [2:0] V_REVERSE = 3'd0;
    localparam logic [2:0] V_SAME    = 3'd1;
    localparam logic [2:0] V_NEW     = 3'd2;
    localparam logic [2:0] V_FORBID  = 3'd3;
    localparam logic [2:0] V_REMOVED = 3'd4;
    localparam logic [2:0] V_IGNORED = 3'd5;

    typedef struct packed {
        logic        op;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] frame_type;
        logic [7:0]  l3_proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [63:0] flow_cookie;
        logic        policy_allows;
        logic [1:0]  remove_reason;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [63:0] matched_cookie;
        logic        table_full;
        logic        cookie_dropped;
    } out_item_t;

    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] frame_type;
        logic [8:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [16:0] src_port;
        logic [16:0] dst_port;
    } key_t;

    typedef logic [COOKIES_PER_SESSION-1:0][63:0] cookie_row_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_A,
        S_SCAN_B,
        S_HIT_A,
        S_HIT_B,
        S_NEW,
        S_SHIFT_A,
        S_SHIFT_B
    } state_t;

endpackage

FILE: rtl/stc_cookie_unit.sv
// cookie set unit: membership test and smallest cookie of one entry row
// depends on stc_pkg
module stc_cookie_unit (
    input  stc_pkg::cookie_row_t        row,
    input  logic [stc_pkg::CNT_W-1:0]   count,
    input  logic [63:0]                 cookie,
    output logic                        holds,
    output logic [63:0]                 smallest
);
    import stc_pkg::*;

    // membership over the filled slots
    always_comb
    begin
        holds = 1'b0;
        for (int k = 0; k < COOKIES_PER_SESSION; k++)
        begin
            if ((CNT_W'(k) < count) && (row[k] == cookie))
                holds = 1'b1;
        end
    end

    // minimum over the filled slots, slot zero always taken
    always_comb
    begin
        smallest = row[0];
        for (int k = 1; k < COOKIES_PER_SESSION; k++)
        begin
            if ((CNT_W'(k) < count) && (row[k] < smallest))
                smallest = row[k];
        end
    end

endmodule

FILE: rtl/session_table_with_reverse_match.sv
// session table: each entry read (SCAN_A) then compared (SCAN_B), entries stay packed in order
// packet: scan stops at a reverse match; else a same match passes HIT_A, no match NEW
// remove: scan up to the holding session, later sessions shifted up (SHIFT_A, SHIFT_B)
// every item ends with the hand-off (HIT_B); the next item is taken only back in S_IDLE
// result sits in an output register, next item taken meanwhile
// reset empties the table (session count and cookie counts cleared), no clearing pass
`include "assert_macros.svh"
module session_table_with_reverse_match (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  stc_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output stc_pkg::out_item_t out_item
);
    import stc_pkg::*;

    // storage
    key_t        key_mem [SESSIONS];
    cookie_row_t ck_mem  [SESSIONS];
    key_t        key_rd_reg;
    cookie_row_t ck_rd_reg;

    logic [CNT_W-1:0] cnt_reg [SESSIONS];
    logic [CNT_W-1:0] cnt_next [SESSIONS];

    state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic        same_found_reg, same_found_next;
    in_item_t    req_reg, req_next;
    key_t        key_reg, key_next;
    out_item_t   res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    logic        key_we;
    logic [IDX_W-1:0] key_waddr;
    key_t        key_wdata;
    logic        ck_we;
    logic [IDX_W-1:0] ck_waddr;
    cookie_row_t ck_wdata;

    logic        holds;
    logic [63:0] smallest;
    logic        last;
    logic        common, rev_hit, same_hit;
    logic        ipv4, l4;
    key_t        in_key;
    logic [CNT_W-1:0] cur_cnt;

    assign cur_cnt = cnt_reg[idx_reg];

    stc_cookie_unit u_cookie (
        .row      (ck_rd_reg),
        .count    (cur_cnt),
        .cookie   (req_reg.flow_cookie),
        .holds    (holds),
        .smallest (smallest)
    );

    // memories: one write port, registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= key_wdata;
        if (ck_we)
            ck_mem[ck_waddr] <= ck_wdata;
        key_rd_reg <= key_mem[idx_reg];
        ck_rd_reg  <= ck_mem[idx_reg];
    end

    // key normalization of the incoming packet
    always_comb
    begin
        ipv4 = (in_item.frame_type == ETH_IPV4);
        l4   = ipv4 && ((in_item.l3_proto == PROTO_TCP) || (in_item.l3_proto == PROTO_UDP));
        in_key.src_mac    = in_item.src_mac;
        in_key.dst_mac    = in_item.dst_mac;
        in_key.frame_type = in_item.frame_type;
        in_key.proto    = ipv4 ? {1'b0, in_item.l3_proto} : PROTO_ABSENT;
        in_key.src_ip   = ipv4 ? in_item.src_ip : IP_ABSENT;
        in_key.dst_ip   = ipv4 ? in_item.dst_ip : IP_ABSENT;
        in_key.src_port = l4 ? {1'b0, in_item.src_port} : PORT_ABSENT;
        in_key.dst_port = l4 ? {1'b0, in_item.dst_port} : PORT_ABSENT;
    end

    // entry compare against the stored key
    always_comb
    begin
        common   = (key_rd_reg.frame_type == key_reg.frame_type)
                   && (key_rd_reg.proto == key_reg.proto);
        rev_hit  = common && (key_rd_reg.dst_mac == key_reg.src_mac)
                   && (key_rd_reg.src_mac == key_reg.dst_mac)
                   && (key_rd_reg.dst_ip == key_reg.src_ip)
                   && (key_rd_reg.src_ip == key_reg.dst_ip)
                   && (key_rd_reg.dst_port == key_reg.src_port)
                   && (key_rd_reg.src_port == key_reg.dst_port);
        same_hit = common && (key_rd_reg.src_mac == key_reg.src_mac)
                   && (key_rd_reg.dst_mac == key_reg.dst_mac)
                   && (key_rd_reg.src_ip == key_reg.src_ip)
                   && (key_rd_reg.dst_ip == key_reg.dst_ip)
                   && (key_rd_reg.src_port == key_reg.src_port)
                   && (key_rd_reg.dst_port == key_reg.dst_port);
        last     = ((N_W'(idx_reg) + N_W'(1)) == n_reg);
    end

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            same_found_reg <= 1'b0;
            for (int i = 0; i < SESSIONS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            out_valid_reg  <= out_valid_next;
            same_found_reg <= same_found_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        req_reg      <= req_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        n_next          = n_reg;
        same_found_next = same_found_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        res_next        = res_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_item_next   = out_item_reg;
        key_we          = 1'b0;
        key_waddr       = idx_reg;
        key_wdata       = key_reg;
        ck_we           = 1'b0;
        ck_waddr        = idx_reg;
        ck_wdata        = ck_rd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = in_item;
                    key_next        = in_key;
                    idx_next        = '0;
                    same_found_next = 1'b0;
                    res_next        = '0;
                    if (in_item.op == OP_REMOVE)
                    begin
                        if ((in_item.remove_reason > REASON_HARD) || (n_reg == '0))
                        begin
                            res_next.verdict = V_IGNORED;
                            state_next = S_HIT_B;
                        end
                        else
                            state_next = S_SCAN_A;
                    end
                    else if (n_reg == '0)
                        state_next = S_NEW;
                    else
                        state_next = S_SCAN_A;
                end
            end
            S_SCAN_A:
            begin
                state_next = S_SCAN_B;
            end
            S_SCAN_B:
            begin
                if (req_reg.op == OP_REMOVE)
                begin
                    if (holds)
                    begin
                        res_next.verdict        = V_REMOVED;
                        res_next.matched_cookie = smallest;
                        if (last)
                        begin
                            cnt_next[idx_reg] = '0;
                            n_next     = n_reg - N_W'(1);
                            state_next = S_HIT_B;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_SHIFT_A;
                        end
                    end
                    else if (last)
                    begin
                        res_next.verdict = V_IGNORED;
                        state_next = S_HIT_B;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_SCAN_A;
                    end
                end
                else if (rev_hit)
                begin
                    res_next.verdict        = V_REVERSE;
                    res_next.matched_cookie = smallest;
                    state_next = S_HIT_B;
                end
                else
                begin
                    if (same_hit && !same_found_reg)
                    begin
                        same_found_next = 1'b1;
                        hit_next        = idx_reg;
                    end
                    if (!last)
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_SCAN_A;
                    end
                    else if (same_found_reg || same_hit)
                    begin
                        idx_next   = (same_found_reg) ? hit_reg : idx_reg;
                        state_next = S_HIT_A;
                    end
                    else
                        state_next = S_NEW;
                end
            end
            S_HIT_A:
            begin
                // same-direction entry: the first pass waits for the row read
                res_next.verdict = V_SAME;
                same_found_next  = 1'b0;
                if (!same_found_reg)
                begin
                    // row valid, apply the cookie
                    res_next.matched_cookie = smallest;
                    if (!holds)
                    begin
                        if (cur_cnt < CNT_W'(COOKIES_PER_SESSION))
                        begin
                            ck_we    = 1'b1;
                            ck_waddr = idx_reg;
                            ck_wdata = ck_rd_reg;
                            ck_wdata[cur_cnt[SLOT_W-1:0]] = req_reg.flow_cookie;
                            cnt_next[idx_reg] = cur_cnt + CNT_W'(1);
                        end
                        else
                            res_next.cookie_dropped = 1'b1;
                    end
                    state_next = S_HIT_B;
                end
            end
            S_HIT_B:
            begin
                // result hand-off into the output register
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            S_NEW:
            begin
                if (req_reg.policy_allows)
                begin
                    res_next.verdict = V_NEW;
                    if (n_reg < N_W'(SESSIONS))
                    begin
                        key_we    = 1'b1;
                        key_waddr = n_reg[IDX_W-1:0];
                        key_wdata = key_reg;
                        ck_we     = 1'b1;
                        ck_waddr  = n_reg[IDX_W-1:0];
                        ck_wdata  = '0;
                        ck_wdata[0] = req_reg.flow_cookie;
                        cnt_next[n_reg[IDX_W-1:0]] = CNT_W'(1);
                        n_next    = n_reg + N_W'(1);
                    end
                    else
                        res_next.table_full = 1'b1;
                end
                else
                    res_next.verdict = V_FORBID;
                state_next = S_HIT_B;
            end
            S_SHIFT_A:
            begin
                state_next = S_SHIFT_B;
            end
            S_SHIFT_B:
            begin
                // move entry idx up by one slot
                key_we    = 1'b1;
                key_waddr = idx_reg - IDX_W'(1);
                key_wdata = key_rd_reg;
                ck_we     = 1'b1;
                ck_waddr  = idx_reg - IDX_W'(1);
                ck_wdata  = ck_rd_reg;
                cnt_next[idx_reg - IDX_W'(1)] = cur_cnt;
                if (last)
                begin
                    cnt_next[idx_reg] = '0;
                    n_next     = n_reg - N_W'(1);
                    state_next = S_HIT_B;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SHIFT_A;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // checks
    `ASSERT_IMPLIES(a_count_bound, 1'b1, n_reg <= N_W'(SESSIONS))
    `ASSERT_NEXT(a_count_step, state_reg == S_IDLE, n_reg == $past(n_reg))
    `ASSERT_IMPLIES(a_result_source, $rose(out_valid_reg), $past(state_reg) == S_HIT_B)

endmodule

FILE: tb/tb_session_table_with_reverse_match.sv
// self-checking testbench for the session table with reverse-direction match
// depends on stc_pkg and session_table_with_reverse_match; predicts every result in-line
module tb_session_table_with_reverse_match;
    timeunit 1ns;
    timeprecision 1ps;
    import stc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    session_table_with_reverse_match u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // session state of the predictor
    key_t        sess_key [SESSIONS];
    logic [63:0] sess_cookie [SESSIONS][COOKIES_PER_SESSION];
    int          sess_cnt [SESSIONS];
    int          sess_n;

    out_item_t   verdict_q [$];
    int          errors;
    int          sent;
    int          checked;
    int          verdict_seen [8];
    int          full_seen;
    int          drop_seen;

    // idling controls
    bit          gap_en;
    bit          stall_en;
    int          hold_left;

    in_item_t    flow_pool [10];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit holds_cookie(int e, logic [63:0] c);
        for (int k = 0; k < sess_cnt[e]; k++)
            if (sess_cookie[e][k] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [63:0] min_cookie(int e);
        logic [63:0] m;
        m = sess_cookie[e][0];
        for (int k = 1; k < sess_cnt[e]; k++)
            if (sess_cookie[e][k] < m)
                m = sess_cookie[e][k];
        return m;
    endfunction

    // compute the verdict of one transaction and update the session state
    function automatic out_item_t table_verdict(in_item_t it);
        out_item_t r;
        key_t      k;
        int        rev;
        int        same;
        int        hit;
        bit        ipv4;
        bit        l4;
        bit        common;
        r = '0;
        rev = -1;
        same = -1;
        hit = -1;
        if (it.op == OP_REMOVE)
        begin
            r.verdict = V_IGNORED;
            if (it.remove_reason <= REASON_HARD)
            begin
                for (int i = 0; i < sess_n && hit < 0; i++)
                    if (holds_cookie(i, it.flow_cookie))
                        hit = i;
                if (hit >= 0)
                begin
                    r.verdict = V_REMOVED;
                    r.matched_cookie = min_cookie(hit);
                    for (int i = hit; i + 1 < sess_n; i++)
                    begin
                        sess_key[i] = sess_key[i + 1];
                        sess_cookie[i] = sess_cookie[i + 1];
                        sess_cnt[i] = sess_cnt[i + 1];
                    end
                    sess_n--;
                    sess_cnt[sess_n] = 0;
                end
            end
            return r;
        end
        // normalise the key
        ipv4 = (it.frame_type == ETH_IPV4);
        l4 = ipv4 && (it.l3_proto == PROTO_TCP || it.l3_proto == PROTO_UDP);
        k.src_mac = it.src_mac;
        k.dst_mac = it.dst_mac;
        k.frame_type = it.frame_type;
        k.proto = ipv4 ? {1'b0, it.l3_proto} : PROTO_ABSENT;
        k.src_ip = ipv4 ? it.src_ip : IP_ABSENT;
        k.dst_ip = ipv4 ? it.dst_ip : IP_ABSENT;
        k.src_port = l4 ? {1'b0, it.src_port} : PORT_ABSENT;
        k.dst_port = l4 ? {1'b0, it.dst_port} : PORT_ABSENT;
        for (int i = 0; i < sess_n; i++)
        begin
            common = sess_key[i].frame_type == k.frame_type && sess_key[i].proto == k.proto;
            if (rev < 0 && common && sess_key[i].dst_mac == k.src_mac
                    && sess_key[i].src_mac == k.dst_mac && sess_key[i].dst_ip == k.src_ip
                    && sess_key[i].src_ip == k.dst_ip && sess_key[i].dst_port == k.src_port
                    && sess_key[i].src_port == k.dst_port)
                rev = i;
            if (same < 0 && common && sess_key[i] == k)
                same = i;
        end
        if (rev >= 0)
        begin
            r.verdict = V_REVERSE;
            r.matched_cookie = min_cookie(rev);
        end
        else if (same >= 0)
        begin
            r.verdict = V_SAME;
            r.matched_cookie = min_cookie(same);
            if (!holds_cookie(same, it.flow_cookie))
            begin
                if (sess_cnt[same] < COOKIES_PER_SESSION)
                begin
                    sess_cookie[same][sess_cnt[same]] = it.flow_cookie;
                    sess_cnt[same]++;
                end
                else
                begin
                    r.cookie_dropped = 1'b1;
                end
            end
        end
        else if (it.policy_allows)
        begin
            r.verdict = V_NEW;
            if (sess_n < SESSIONS)
            begin
                sess_key[sess_n] = k;
                sess_cookie[sess_n][0] = it.flow_cookie;
                sess_cnt[sess_n] = 1;
                sess_n++;
            end
            else
            begin
                r.table_full = 1'b1;
            end
        end
        else
        begin
            r.verdict = V_FORBID;
        end
        return r;
    endfunction

    // random content for every field of one transaction
    function automatic in_item_t random_fill();
        logic [319:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t packet(logic [47:0] smac, logic [47:0] dmac,
            logic [15:0] et, logic [7:0] proto, logic [31:0] sip, logic [31:0] dip,
            logic [15:0] sp, logic [15:0] dp, logic [63:0] cookie, logic allow);
        in_item_t it;
        it = '0;
        it.op = OP_PACKET;
        it.src_mac = smac;
        it.dst_mac = dmac;
        it.frame_type = et;
        it.l3_proto = proto;
        it.src_ip = sip;
        it.dst_ip = dip;
        it.src_port = sp;
        it.dst_port = dp;
        it.flow_cookie = cookie;
        it.policy_allows = allow;
        return it;
    endfunction

    function automatic in_item_t removal(logic [63:0] cookie, logic [1:0] reason);
        in_item_t it;
        it = random_fill();
        it.op = OP_REMOVE;
        it.flow_cookie = cookie;
        it.remove_reason = reason;
        return it;
    endfunction

    // offer one transaction, predict it once accepted
    task automatic send_item(in_item_t it);
        bit taken;
        if (gap_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        verdict_q.insert(verdict_q.size(), table_verdict(it));
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // empty table, normalisation, reverse and same matches, cookie sets, removes
    task automatic test_directed();
        logic [47:0] ma;
        logic [47:0] mb;
        ma = 48'h0200_0000_00aa;
        mb = 48'h0200_0000_00bb;
        send_item(removal(64'd3, REASON_IDLE));
        send_item(packet(ma, mb, 16'h86dd, 8'd6, 32'd1, 32'd2, 16'd3, 16'd4, 64'd1, 1'b0));
        send_item(packet(ma, mb, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'h0a000002,
                         16'd1000, 16'd80, 64'd0, 1'b1));
        send_item(packet(ma, mb, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'h0a000002,
                         16'd1000, 16'd80, 64'd5, 1'b0));
        send_item(packet(mb, ma, ETH_IPV4, PROTO_TCP, 32'h0a000002, 32'h0a000001,
                         16'd80, 16'd1000, 64'd9, 1'b0));
        send_item(packet(ma, mb, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'h0a000002,
                         16'd1000, 16'd80, 64'd5, 1'b0));
        send_item(packet(ma, mb, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'h0a000002,
                         16'd1000, 16'd80, 64'd7, 1'b0));
        send_item(packet(ma, mb, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'h0a000002,
                         16'd1000, 16'd80, '1, 1'b0));
        send_item(packet(ma, mb, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'h0a000002,
                         16'd1000, 16'd80, 64'd11, 1'b0));
        // non-ip key ignores protocol, addresses and ports
        send_item(packet(ma, ma, 16'h0806, 8'd1, 32'd1, 32'd2, 16'd3, 16'd4, 64'd20, 1'b1));
        send_item(packet(ma, ma, 16'h0806, 8'd99, 32'd7, 32'd8, 16'd9, 16'd10, 64'd21, 1'b0));
        // non-l4 protocol ignores ports, udp keeps them
        send_item(packet(mb, ma, ETH_IPV4, 8'd1, 32'd5, 32'd6, 16'd1, 16'd2, 64'd30, 1'b1));
        send_item(packet(mb, ma, ETH_IPV4, 8'd1, 32'd5, 32'd6, 16'hffff, 16'd0, 64'd31,
                         1'b0));
        send_item(packet(mb, ma, ETH_IPV4, PROTO_UDP, 32'd5, 32'd6, 16'd1, 16'd2, 64'd32,
                         1'b0));
        send_item(packet('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
        send_item(packet('0, '0, ETH_IPV4, PROTO_UDP, '0, '0, '0, '0, '0, 1'b1));
        // delete and group delete are ignored, unknown cookie ignored
        send_item(removal(64'd5, REASON_DELETE));
        send_item(removal(64'd5, REASON_GROUP));
        send_item(removal(64'd12345, REASON_IDLE));
        send_item(removal(64'd7, REASON_HARD));
        send_item(removal(64'd21, REASON_IDLE));
        send_item(removal('1, REASON_IDLE));
        wait_drained();
    endtask

    // fill all sessions, overflow, then empty again
    task automatic test_table_full();
        while (sess_n < SESSIONS)
            send_item(packet(48'h1, 48'h1000 + 48'(sess_n), 16'h9000, '0, '0, '0, '0, '0,
                             64'h100 + 64'(sess_n), 1'b1));
        send_item(packet(48'h1, 48'h3, 16'h9000, '0, '0, '0, '0, '0, 64'h999, 1'b1));
        while (sess_n > 0)
            send_item(removal(sess_cookie[$urandom_range(0, sess_n - 1)][0], REASON_IDLE));
        wait_drained();
    endtask

    // receiver holds off a long stretch while items keep coming
    task automatic test_backpressure();
        hold_left = 250;
        for (int j = 0; j < 8; j++)
            send_item(packet(48'h5, 48'h6, ETH_IPV4, PROTO_UDP, 32'(j), 32'd9, 16'(j),
                             16'd9, 64'(j), 1'b1));
        wait_drained();
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // noise
            it = random_fill();
        end
        else if (pick < 40)
        begin
            it = removal($urandom_range(0, 3) == 0 ? {$urandom, $urandom} :
                         64'($urandom_range(0, 15)),
                         $urandom_range(0, 4) == 0 ? 2'($urandom_range(2, 3)) :
                         2'($urandom_range(0, 1)));
        end
        else
        begin
            it = flow_pool[$urandom_range(0, 9)];
            // reverse direction of a pool flow
            if ($urandom_range(0, 2) == 0)
                it = packet(it.dst_mac, it.src_mac, it.frame_type, it.l3_proto, it.dst_ip,
                            it.src_ip, it.dst_port, it.src_port, '0, 1'b0);
            if (it.frame_type != ETH_IPV4)
            begin
                it.l3_proto = 8'($urandom);
                it.src_ip = $urandom;
                it.dst_ip = $urandom;
            end
            if (it.frame_type != ETH_IPV4 || !(it.l3_proto == PROTO_TCP
                    || it.l3_proto == PROTO_UDP))
            begin
                it.src_port = 16'($urandom);
                it.dst_port = 16'($urandom);
            end
            it.flow_cookie = $urandom_range(0, 7) == 0 ? {$urandom, $urandom} :
                             64'($urandom_range(0, 15));
            it.policy_allows = $urandom_range(0, 3) != 0;
            it.remove_reason = 2'($urandom);
        end
        return it;
    endfunction

    // mostly related flows with random content, idling on both sides when with_idle is set
    task automatic test_random(int count, bit with_idle);
        gap_en = with_idle;
        stall_en = with_idle;
        for (int j = 0; j < count; j++)
            send_item(random_item());
    endtask

    // pool of flow keys that random packets draw from
    task automatic build_pool();
        logic [7:0] protos [4];
        protos = '{PROTO_TCP, PROTO_UDP, 8'd1, 8'd0};
        for (int j = 0; j < 10; j++)
        begin
            flow_pool[j] = packet(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  j < 7 ? ETH_IPV4 : 16'($urandom), protos[j % 4],
                                  $urandom, $urandom, 16'($urandom), 16'($urandom),
                                  '0, 1'b0);
        end
    endtask

    // result checker, sampled mid-cycle before the accepting edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result transaction verdict %0d", out_item.verdict);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = verdict_q.pop_front();
                checked++;
                verdict_seen[e.verdict]++;
                full_seen += e.table_full;
                drop_seen += e.cookie_dropped;
                if (out_item.verdict !== e.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", e.verdict, out_item.verdict);
                    errors++;
                end
                if (out_item.matched_cookie !== e.matched_cookie)
                begin
                    $error("matched_cookie: expected %h, got %h", e.matched_cookie,
                           out_item.matched_cookie);
                    errors++;
                end
                if (out_item.table_full !== e.table_full)
                begin
                    $error("table_full: expected %0d, got %0d", e.table_full,
                           out_item.table_full);
                    errors++;
                end
                if (out_item.cookie_dropped !== e.cookie_dropped)
                begin
                    $error("cookie_dropped: expected %0d, got %0d", e.cookie_dropped,
                           out_item.cookie_dropped);
                    errors++;
                end
            end
        end
    end

    // receiver stall: long hold on request, else random bursts
    initial
    begin
        int burst;
        burst = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (stall_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(0, 8);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[session_table_with_reverse_match] ERROR");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        errors = 0;
        sent = 0;
        checked = 0;
        sess_n = 0;
        gap_en = 1'b1;
        stall_en = 1'b1;
        hold_left = 0;
        for (int i = 0; i < SESSIONS; i++)
            sess_cnt[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_pool();
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(490, 1'b1);
        wait_drained();
        test_random(100, 1'b0);
        wait_drained();

        $display("covered %0d transactions: reverse %0d same %0d new %0d forbid %0d",
                 checked, verdict_seen[V_REVERSE], verdict_seen[V_SAME],
                 verdict_seen[V_NEW], verdict_seen[V_FORBID]);
        $display("removed %0d, ignored %0d, table full %0d, cookie dropped %0d",
                 verdict_seen[V_REMOVED], verdict_seen[V_IGNORED], full_seen, drop_seen);
        if (errors == 0)
            $display("[session_table_with_reverse_match] OK");
        else
            $display("[session_table_with_reverse_match] ERROR");
        $finish;
    end
endmodule
